// ===== sv/ilrs_pkg.sv =====
package ilrs_pkg;

    // Store geometry.
    localparam int CAPACITY = 1024;
    localparam int LOG      = $clog2(CAPACITY);
    localparam int ADDR_W   = LOG + 1;
    localparam int DEPTH    = 2 * CAPACITY;
    localparam int SPAN_W   = LOG + 2;

    // Field widths.
    localparam int SUM_W = 30;
    localparam int POS_W = 11;
    localparam int VAL_W = 31;

    localparam logic [SUM_W:0] PRIME_MOD  = 31'd1000000007;
    localparam logic [VAL_W-1:0] PRIME_X2 = 31'd2000000014;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_SET    = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_QUERY  = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd               cmd;
        logic [POS_W-1:0]   first_pos;
        logic [POS_W-1:0]   second_pos;
        logic [VAL_W-1:0]   data_value;
    } t_in;

    typedef struct packed {
        logic [SUM_W-1:0] range_sum;
        logic             range_error;
    } t_out;

    // One tree node: value sum and deleted-slot count.
    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [ADDR_W-1:0] del;
    } t_node;

    localparam int NODE_W = $bits(t_node);

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_CLEAR,
        OP_RK_P1,
        OP_RK_P2,
        OP_RK_RD,
        OP_RK_STEP,
        OP_UPD_LEAF,
        OP_UPD_RD,
        OP_UPD_CMB,
        OP_SUM_INIT,
        OP_SUM_LO,
        OP_SUM_HI,
        OP_SUM_SH,
        OP_OUT_OK,
        OP_OUT_ERR
    } t_op;

    typedef struct packed {
        t_cmd cmd;
        logic append_ok;
        logic pos_ok;
        logic qry_ok;
        logic rk_done;
        logic upd_root;
        logic sum_done;
        logic clr_done;
        logic out_free;
    } t_status;

    function automatic logic [SUM_W-1:0] add_mod(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= PRIME_MOD) begin
            s = s - PRIME_MOD;
        end
        return s[SUM_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] reduce(input logic [VAL_W-1:0] v);
        logic [VAL_W-1:0] r;
        if (v >= PRIME_X2) begin
            r = v - PRIME_X2;
        end else if (v >= PRIME_MOD) begin
            r = v - PRIME_MOD;
        end else begin
            r = v;
        end
        return r[SUM_W-1:0];
    endfunction

endpackage

// ===== sv/ilrs_ram.sv =====
module ilrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/ilrs_ctrl.sv =====
module ilrs_ctrl import ilrs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_op     o_op
);

    typedef enum logic [11:0] {
        S_CLEAR   = 12'b000000000001,
        S_IDLE    = 12'b000000000010,
        S_DECODE  = 12'b000000000100,
        S_RK_RD   = 12'b000000001000,
        S_RK_STEP = 12'b000000010000,
        S_UPD_RD  = 12'b000000100000,
        S_UPD_CMB = 12'b000001000000,
        S_SUM_LO  = 12'b000010000000,
        S_SUM_HI  = 12'b000100000000,
        S_SUM_SH  = 12'b001000000000,
        S_OUT_OK  = 12'b010000000000,
        S_OUT_ERR = 12'b100000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_second, n_second;

    // Next-state and operation decode.
    always_comb begin
        n_state    = r_state;
        n_second   = r_second;
        o_op       = OP_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_op = OP_CLEAR;
                if (i_status.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_op    = OP_LATCH;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_second = 1'b0;
                case (i_status.cmd)
                    CMD_APPEND: begin
                        if (i_status.append_ok) begin
                            o_op    = OP_UPD_LEAF;
                            n_state = S_UPD_RD;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    CMD_SET, CMD_DELETE: begin
                        if (i_status.pos_ok) begin
                            o_op    = OP_RK_P1;
                            n_state = S_RK_RD;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        if (i_status.qry_ok) begin
                            o_op    = OP_RK_P1;
                            n_state = S_RK_RD;
                        end else begin
                            n_state = S_OUT_ERR;
                        end
                    end
                endcase
            end
            S_RK_RD: begin
                if (!i_status.rk_done) begin
                    o_op    = OP_RK_RD;
                    n_state = S_RK_STEP;
                end else if (i_status.cmd != CMD_QUERY) begin
                    o_op    = OP_UPD_LEAF;
                    n_state = S_UPD_RD;
                end else if (!r_second) begin
                    o_op     = OP_RK_P2;
                    n_second = 1'b1;
                end else begin
                    o_op    = OP_SUM_INIT;
                    n_state = S_SUM_LO;
                end
            end
            S_RK_STEP: begin
                o_op    = OP_RK_STEP;
                n_state = S_RK_RD;
            end
            S_UPD_RD: begin
                o_op = OP_UPD_RD;
                if (i_status.upd_root) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_UPD_CMB;
                end
            end
            S_UPD_CMB: begin
                o_op    = OP_UPD_CMB;
                n_state = S_UPD_RD;
            end
            S_SUM_LO: begin
                if (i_status.sum_done) begin
                    n_state = S_OUT_OK;
                end else begin
                    o_op    = OP_SUM_LO;
                    n_state = S_SUM_HI;
                end
            end
            S_SUM_HI: begin
                o_op    = OP_SUM_HI;
                n_state = S_SUM_SH;
            end
            S_SUM_SH: begin
                o_op    = OP_SUM_SH;
                n_state = S_SUM_LO;
            end
            S_OUT_OK: begin
                if (i_status.out_free) begin
                    o_op    = OP_OUT_OK;
                    n_state = S_IDLE;
                end
            end
            S_OUT_ERR: begin
                if (i_status.out_free) begin
                    o_op    = OP_OUT_ERR;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_second <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
        end
    end

endmodule

// ===== sv/ilrs_dp.sv =====
module ilrs_dp import ilrs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_op     i_op,
    input  t_in     i_in_data,
    input  logic    i_out_ready,
    output t_status o_status,
    output logic    o_out_valid,
    output t_out    o_out_data
);

    // Control registers.
    logic [ADDR_W-1:0] r_next_slot, n_next_slot;
    logic [ADDR_W-1:0] r_live, n_live;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic              r_pend, n_pend;
    logic              r_out_valid, n_out_valid;

    // Working registers.
    t_cmd              r_cmd, n_cmd;
    logic [POS_W-1:0]  r_p1, n_p1;
    logic [POS_W-1:0]  r_p2, n_p2;
    logic [SUM_W-1:0]  r_val, n_val;
    logic [ADDR_W-1:0] r_n, n_n;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [ADDR_W-1:0] r_size, n_size;
    logic [ADDR_W-1:0] r_idx, n_idx;
    t_node             r_cur, n_cur;
    logic [SPAN_W-1:0] r_lo, n_lo;
    logic [SPAN_W-1:0] r_hi, n_hi;
    logic [SUM_W-1:0]  r_acc, n_acc;
    t_out              r_out, n_out;

    logic              we;
    logic [ADDR_W-1:0] waddr, raddr;
    t_node             wdata, rdata;
    logic [ADDR_W-1:0] zeros;
    logic [SPAN_W-1:0] hi_m1;

    ilrs_ram #(
        .WIDTH (NODE_W),
        .DEPTH (DEPTH)
    ) u_tree (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign zeros = r_size - rdata.del;
    assign hi_m1 = r_hi - SPAN_W'(1);

    // Status back to the controller.
    always_comb begin
        o_status.cmd       = r_cmd;
        o_status.append_ok = (32'(r_next_slot) < CAPACITY);
        o_status.pos_ok    = (r_p1 != '0) && (32'(r_p1) <= 32'(r_live));
        o_status.qry_ok    = (r_p1 != '0) && (32'(r_p2) <= 32'(r_live)) && (r_p1 <= r_p2);
        o_status.rk_done   = r_n[ADDR_W-1];
        o_status.upd_root  = (r_idx == ADDR_W'(1));
        o_status.sum_done  = (r_lo >= r_hi);
        o_status.clr_done  = &r_clr;
        o_status.out_free  = !r_out_valid;
    end

    // Operation execution.
    always_comb begin
        n_next_slot = r_next_slot;
        n_live      = r_live;
        n_clr       = r_clr;
        n_pend      = 1'b0;
        n_out_valid = r_out_valid;
        n_cmd       = r_cmd;
        n_p1        = r_p1;
        n_p2        = r_p2;
        n_val       = r_val;
        n_n         = r_n;
        n_pos       = r_pos;
        n_size      = r_size;
        n_idx       = r_idx;
        n_cur       = r_cur;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_acc       = r_acc;
        n_out       = r_out;
        we          = 1'b0;
        waddr       = r_idx;
        wdata       = r_cur;
        raddr       = {r_n[ADDR_W-2:0], 1'b0};

        // A sum-walk read issued last cycle is folded in now.
        if (r_pend) begin
            n_acc = add_mod(r_acc, rdata.sum);
        end
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (i_op)
            OP_LATCH: begin
                n_cmd = i_in_data.cmd;
                n_p1  = i_in_data.first_pos;
                n_p2  = i_in_data.second_pos;
                n_val = reduce(i_in_data.data_value);
            end
            OP_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr;
                wdata = '0;
                n_clr = r_clr + ADDR_W'(1);
            end
            OP_RK_P1: begin
                n_n    = ADDR_W'(1);
                n_pos  = r_p1;
                n_size = ADDR_W'(CAPACITY / 2);
            end
            OP_RK_P2: begin
                n_lo   = SPAN_W'(r_n);
                n_n    = ADDR_W'(1);
                n_pos  = r_p2;
                n_size = ADDR_W'(CAPACITY / 2);
            end
            OP_RK_RD: begin
                raddr = {r_n[ADDR_W-2:0], 1'b0};
            end
            OP_RK_STEP: begin
                // Descend left when the left child holds enough kept slots.
                if (32'(r_pos) <= 32'(zeros)) begin
                    n_n = {r_n[ADDR_W-2:0], 1'b0};
                end else begin
                    n_n   = {r_n[ADDR_W-2:0], 1'b1};
                    n_pos = r_pos - POS_W'(zeros);
                end
                n_size = r_size >> 1;
            end
            OP_UPD_LEAF: begin
                case (r_cmd)
                    CMD_APPEND: begin
                        n_idx       = {1'b1, r_next_slot[LOG-1:0]};
                        n_cur.sum   = r_val;
                        n_cur.del   = '0;
                        n_next_slot = r_next_slot + ADDR_W'(1);
                        n_live      = r_live + ADDR_W'(1);
                    end
                    CMD_SET: begin
                        n_idx     = r_n;
                        n_cur.sum = r_val;
                        n_cur.del = '0;
                    end
                    CMD_DELETE: begin
                        n_idx     = r_n;
                        n_cur.sum = '0;
                        n_cur.del = ADDR_W'(1);
                        n_live    = r_live - ADDR_W'(1);
                    end
                    default: begin
                        n_idx = r_idx;
                    end
                endcase
            end
            OP_UPD_RD: begin
                // Write the current node and fetch its sibling.
                we    = 1'b1;
                raddr = r_idx ^ ADDR_W'(1);
            end
            OP_UPD_CMB: begin
                n_cur.sum = add_mod(r_cur.sum, rdata.sum);
                n_cur.del = r_cur.del + rdata.del;
                n_idx     = r_idx >> 1;
            end
            OP_SUM_INIT: begin
                n_hi  = SPAN_W'(r_n) + SPAN_W'(1);
                n_acc = '0;
            end
            OP_SUM_LO: begin
                if (r_lo[0]) begin
                    raddr  = r_lo[ADDR_W-1:0];
                    n_lo   = r_lo + SPAN_W'(1);
                    n_pend = 1'b1;
                end
            end
            OP_SUM_HI: begin
                if (r_hi[0]) begin
                    raddr  = hi_m1[ADDR_W-1:0];
                    n_hi   = hi_m1;
                    n_pend = 1'b1;
                end
            end
            OP_SUM_SH: begin
                n_lo = r_lo >> 1;
                n_hi = r_hi >> 1;
            end
            OP_OUT_OK: begin
                n_out.range_sum   = r_acc;
                n_out.range_error = 1'b0;
                n_out_valid       = 1'b1;
            end
            OP_OUT_ERR: begin
                n_out.range_sum   = '0;
                n_out.range_error = 1'b1;
                n_out_valid       = 1'b1;
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    // Control registers with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_slot <= '0;
            r_live      <= '0;
            r_clr       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_next_slot <= n_next_slot;
            r_live      <= n_live;
            r_clr       <= n_clr;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_p1   <= n_p1;
        r_p2   <= n_p2;
        r_val  <= n_val;
        r_n    <= n_n;
        r_pos  <= n_pos;
        r_size <= n_size;
        r_idx  <= n_idx;
        r_cur  <= n_cur;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_acc  <= n_acc;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== sv/indexed_list_range_sum_top.sv =====
// Indexed list store with range sums modulo 1000000007.
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one command per
// transfer: append, set, delete or range-sum query. Output channel
// (o_out_valid / i_out_ready / o_out_data) carries one result per query and
// nothing for the other commands.
// One command is worked at a time over a tree memory with one write port and one
// registered read port, holding value sums and deleted-slot counts. A rank
// descent reads and then steps at each tree level, an update writes a node and
// reads its sibling and then combines them at each level, and a query makes two
// rank descents plus a range walk of low, high and shift steps per level.
// A rejected set, delete or full append returns to idle with no result; an
// out-of-range query returns its error result. The store holds 1024 slots.
// After reset the block clears all 2048 tree-memory nodes, one node per cycle,
// before it raises o_in_ready.
// Results sit in an output register; a stalled receiver holds the result
// there, and the block still takes the next command, blocking only when a
// new query result is ready while the previous one has not been taken.
module indexed_list_range_sum_top import ilrs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_op     op;
    t_status status;

    ilrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_op       (op)
    );

    ilrs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
